[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked, reset-gated property shorthands for the deque checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CBDQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbdq assertion failed");

// Next-cycle implication.
`define CBDQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbdq assertion failed");

`endif

[rtl/cbdq_pkg.sv]
// ----------------------------------------------------------------------------
// Deque package
// Sizes, action and status codes, and the chain control bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package cbdq_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned VAL_W = 31;
  localparam int unsigned RES_W = 32;
  localparam int unsigned OCC_W = 11;
  localparam int unsigned ACT_W = 2;
  localparam int unsigned ST_W  = 2;

  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 2'd3;

  localparam logic [ST_W-1:0] ST_DONE      = 2'd0;
  localparam logic [ST_W-1:0] ST_POP_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_PUSH_FULL = 2'd2;

  localparam logic [RES_W-1:0] NO_VALUE = '1;

  // What a chain of cells does in one cycle.
  typedef enum logic [1:0] {
    SH_HOLD,    // keep every cell
    SH_PUSH,    // shift toward the far end, new value into cell 0
    SH_POP,     // shift toward cell 0
    SH_APPEND   // write the new value into the cell at the current count
  } cbdq_shift_e;

  typedef struct packed {
    cbdq_shift_e       op;
    logic [CNT_W-1:0]  count;
    logic [VAL_W-1:0]  value;
  } cbdq_ctl_t;

endpackage

`default_nettype wire

[rtl/cbdq_if.sv]
// ----------------------------------------------------------------------------
// Deque channel interfaces
// Valid/ready channels for action beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbdq_req_if import cbdq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [VAL_W-1:0]  push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface cbdq_rsp_if import cbdq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [RES_W-1:0]  popped_value;
  logic [ST_W-1:0]          status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output popped_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input popped_value, input status, input occupancy,
                  output ready);
endinterface

`default_nettype wire

[rtl/cbdq_cell.sv]
// ----------------------------------------------------------------------------
// Deque cell
// One entry of a shifting chain: hold, take a neighbor, or load a new value.
// ----------------------------------------------------------------------------
`default_nettype none

module cbdq_cell import cbdq_pkg::*; (
  input  wire logic              clk_i,
  input  wire cbdq_shift_e       op_i,
  input  wire logic              hit_i,
  input  wire logic [VAL_W-1:0]  lower_i,
  input  wire logic [VAL_W-1:0]  upper_i,
  input  wire logic [VAL_W-1:0]  value_i,
  output logic      [VAL_W-1:0]  data_o
);

  logic [VAL_W-1:0] data_d, data_q;

  always_comb begin
    data_d = data_q;
    case (op_i)
      SH_PUSH:   data_d = lower_i;
      SH_POP:    data_d = upper_i;
      SH_APPEND: if (hit_i) data_d = value_i;
      default:   data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[rtl/cbdq_chain.sv]
// ----------------------------------------------------------------------------
// Deque chain
// A row of cells with one end at cell 0; entries beyond the count are stale.
// ----------------------------------------------------------------------------
`default_nettype none

module cbdq_chain import cbdq_pkg::*; (
  input  wire logic              clk_i,
  input  wire cbdq_ctl_t         ctl_i,
  output logic      [VAL_W-1:0]  head_o
);

  logic [VAL_W-1:0] data [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] lower;
    logic [VAL_W-1:0] upper;
    logic             hit;

    if (i == 0) begin : g_first
      assign lower = ctl_i.value;
    end else begin : g_mid_lo
      assign lower = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = data[i];
    end else begin : g_mid_hi
      assign upper = data[i+1];
    end

    assign hit = (ctl_i.count == CNT_W'(i));

    cbdq_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (ctl_i.op),
      .hit_i   (hit),
      .lower_i (lower),
      .upper_i (upper),
      .value_i (ctl_i.value),
      .data_o  (data[i])
    );
  end

  assign head_o = data[0];

endmodule

`default_nettype wire

[rtl/circular_buffer_deque.sv]
// ----------------------------------------------------------------------------
// Circular buffer deque
// Double-ended queue of DEPTH entries built from two shifting cell chains.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     beat fields
//   -------  ---  ------------  -----------------------------------------
//   req_i    in   valid/ready   action, push_value
//   rsp_o    out  valid/ready   popped_value, status, occupancy
//
// One action beat is taken per cycle; its result beat is registered and appears in the next cycle.
// A new action is taken while the result register is empty or is drained in
// the same cycle, so a stalled result holds the next action back.
// Reset clears the count and the result valid at once; cells are not cleared.
// No clearing pass: only entries inside the count are ever read.
//
// Two chains store the contents twice. The front chain keeps the front entry in
// cell 0 and runs toward the back; the back chain keeps the back entry in cell 0
// and runs toward the front. A push shifts one chain by a cell and writes the
// other at the count, a pop shifts only its own; both ends always sit at cell 0.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_buffer_deque import cbdq_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cbdq_req_if.sink   req_i,
  cbdq_rsp_if.source rsp_o
);

  logic [CNT_W-1:0] cnt_d, cnt_q;
  logic             rsp_valid_q;
  logic [RES_W-1:0] res_d, res_q;
  logic [ST_W-1:0]  st_d, st_q;
  logic [OCC_W-1:0] occ_q;

  logic             accept;
  logic             empty;
  logic             full;
  logic [VAL_W-1:0] front_head;
  logic [VAL_W-1:0] back_head;
  cbdq_shift_e      front_op;
  cbdq_shift_e      back_op;
  cbdq_ctl_t        front_ctl;
  cbdq_ctl_t        back_ctl;

  // Take a beat whenever the result slot is free or drains this cycle.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign empty = (cnt_q == '0);
  assign full  = (cnt_q == CNT_W'(DEPTH));

  // Decode the action into chain moves, the count update and the result.
  always_comb begin
    front_op = SH_HOLD;
    back_op  = SH_HOLD;
    cnt_d    = cnt_q;
    res_d    = NO_VALUE;
    st_d     = ST_DONE;
    if (accept) begin
      unique case (req_i.action) inside
        ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
          if (full) begin
            // Drop the value, keep the state.
            st_d = ST_PUSH_FULL;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
            if (req_i.action == ACT_PUSH_FRONT) begin
              front_op = SH_PUSH;
              back_op  = SH_APPEND;
            end else begin
              front_op = SH_APPEND;
              back_op  = SH_PUSH;
            end
          end
        end
        ACT_POP_FRONT: begin
          if (empty) begin
            st_d = ST_POP_EMPTY;
          end else begin
            // The far copy in the back chain falls outside the new count.
            res_d    = RES_W'(front_head);
            front_op = SH_POP;
            cnt_d    = cnt_q - CNT_W'(1);
          end
        end
        ACT_POP_BACK: begin
          if (empty) begin
            st_d = ST_POP_EMPTY;
          end else begin
            res_d   = RES_W'(back_head);
            back_op = SH_POP;
            cnt_d   = cnt_q - CNT_W'(1);
          end
        end
        default: begin
          st_d = ST_DONE;
        end
      endcase
    end
  end

  assign front_ctl = '{op: front_op, count: cnt_q, value: req_i.push_value};
  assign back_ctl  = '{op: back_op,  count: cnt_q, value: req_i.push_value};

  cbdq_chain u_front (
    .clk_i  (clk_i),
    .ctl_i  (front_ctl),
    .head_o (front_head)
  );

  cbdq_chain u_back (
    .clk_i  (clk_i),
    .ctl_i  (back_ctl),
    .head_o (back_head)
  );

  // Control state: count and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on every accepted beat, hold while stalled.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
      st_q  <= st_d;
      occ_q <= OCC_W'(cnt_d);
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.popped_value = res_q;
  assign rsp_o.status       = st_q;
  assign rsp_o.occupancy    = occ_q;

endmodule

`default_nettype wire

[rtl/cbdq_checker.sv]
// ----------------------------------------------------------------------------
// Deque checker
// Port-level checks on result beats, bound to the deque top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cbdq_checker import cbdq_pkg::*; (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     rsp_valid_i,
  input wire logic                     rsp_ready_i,
  input wire logic signed [RES_W-1:0]  popped_value_i,
  input wire logic [ST_W-1:0]          status_i,
  input wire logic [OCC_W-1:0]         occupancy_i
);

  logic                         rsp_stall;
  logic                         rsp_fail;
  logic                         rsp_empty;
  logic                         rsp_full;
  logic [RES_W+ST_W+OCC_W-1:0]  rsp_beat;

  assign rsp_stall = rsp_valid_i && !rsp_ready_i;
  assign rsp_fail  = rsp_valid_i && (status_i != ST_DONE);
  assign rsp_empty = rsp_valid_i && (status_i == ST_POP_EMPTY);
  assign rsp_full  = rsp_valid_i && (status_i == ST_PUSH_FULL);
  assign rsp_beat  = {popped_value_i, status_i, occupancy_i};

  // A stalled result beat stays up with the same payload.
  `CBDQ_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, rsp_stall, rsp_valid_i && $stable(rsp_beat))

  // A failed action never returns a value.
  `CBDQ_ASSERT_IMP(a_fail_no_value, clk_i, rst_ni, rsp_fail, popped_value_i == NO_VALUE)

  // A pop is refused only on an empty deque.
  `CBDQ_ASSERT_IMP(a_empty_occ, clk_i, rst_ni, rsp_empty, occupancy_i == '0)

  // A push is dropped only on a full deque.
  `CBDQ_ASSERT_IMP(a_full_occ, clk_i, rst_ni, rsp_full, occupancy_i == OCC_W'(DEPTH))

endmodule

bind circular_buffer_deque cbdq_checker u_cbdq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .popped_value_i (rsp_o.popped_value),
  .status_i       (rsp_o.status),
  .occupancy_i    (rsp_o.occupancy)
);

`default_nettype wire
